// ----- src/dmc_pkg.sv -----
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared widths, codes and types for the direct-mapped cache read unit.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam int unsigned KIND_W  = 1;
  localparam int unsigned ADDR_W  = 10;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 16;

  localparam logic [KIND_W-1:0]  KIND_LOAD   = 1'b0;
  localparam logic [KIND_W-1:0]  KIND_ACCESS = 1'b1;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FILL,
    ST_RESP
  } state_t;

endpackage

// ----- src/dmc_channels.sv -----
// ----------------------------------------------------------------------------
// dmc channels
// Valid/ready channels for the request word and the result word.
// ----------------------------------------------------------------------------
interface dmc_in_if;
  logic                        valid;
  logic                        ready;
  logic [dmc_pkg::KIND_W-1:0]  kind;
  logic [dmc_pkg::ADDR_W-1:0]  address;
  logic [dmc_pkg::BYTE_W-1:0]  load_byte;

  modport source (output valid, output kind, output address, output load_byte,
                  input ready);
  modport sink   (input valid, input kind, input address, input load_byte,
                  output ready);
endinterface

interface dmc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [dmc_pkg::BYTE_W-1:0]  read_byte;
  logic [dmc_pkg::COUNT_W-1:0] miss_total;
  logic [dmc_pkg::COUNT_W-1:0] hit_total;

  modport source (output valid, output hit, output read_byte, output miss_total,
                  output hit_total, input ready);
  modport sink   (input valid, input hit, input read_byte, input miss_total,
                  input hit_total, output ready);
endinterface

// ----- src/dmc_ram.sv -----
// ----------------------------------------------------------------------------
// dmc_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module dmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- src/direct_mapped_cache_read_unit.sv -----
// ----------------------------------------------------------------------------
// direct_mapped_cache_read_unit
// Read-only direct-mapped cache in front of a byte RAM, with saturating
// hit and miss counters.
// ----------------------------------------------------------------------------
// A load word writes one byte of the backing RAM. An access word reads the
// tag and data stores in its accept cycle and compares in the next. A miss
// streams the line through the single RAM port, one byte a cycle. One word
// is in flight at a time; a finished result waits in the output register
// while the next word is taken. LINE_COUNT, LINE_BYTES and RAM_BYTES must be
// powers of two; addresses wrap at RAM_BYTES. Loads do not update cached lines.
module direct_mapped_cache_read_unit #(
  parameter int unsigned LINE_COUNT = 4,
  parameter int unsigned LINE_BYTES = 8,
  parameter int unsigned RAM_BYTES  = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  dmc_in_if.sink    in_ch,
  dmc_out_if.source out_ch
);

  localparam int unsigned RAM_AW  = $clog2(RAM_BYTES);
  localparam int unsigned OFF_W   = $clog2(LINE_BYTES);
  localparam int unsigned LCNT_W  = $clog2(LINE_COUNT);
  localparam int unsigned LINE_W  = (LINE_COUNT > 1) ? LCNT_W : 1;
  localparam int unsigned TAG_W   = (RAM_AW > OFF_W + LCNT_W) ? RAM_AW - OFF_W - LCNT_W : 1;
  localparam int unsigned DATA_AW = $clog2(LINE_COUNT * LINE_BYTES);
  localparam int unsigned FCNT_W  = OFF_W + 1;

  dmc_pkg::state_t state_r, state_nxt;

  logic [dmc_pkg::KIND_W-1:0]  kind_r;
  logic [RAM_AW-1:0]           addr_r;
  logic [FCNT_W-1:0]           fill_cnt_r;
  logic [LINE_COUNT-1:0]       valid_r;
  logic                        res_hit_r;
  logic [dmc_pkg::BYTE_W-1:0]  res_byte_r;
  logic [dmc_pkg::COUNT_W-1:0] miss_cnt_r;
  logic [dmc_pkg::COUNT_W-1:0] hit_cnt_r;
  logic                        out_valid_r;
  logic                        out_hit_r;
  logic [dmc_pkg::BYTE_W-1:0]  out_byte_r;
  logic [dmc_pkg::COUNT_W-1:0] out_miss_r;
  logic [dmc_pkg::COUNT_W-1:0] out_hits_r;

  logic [dmc_pkg::ADDR_W+RAM_AW-1:0] in_addr_ext;
  logic [RAM_AW-1:0]  in_ram_addr;
  logic [LINE_W-1:0]  in_line;
  logic [OFF_W-1:0]   in_off;
  logic [LINE_W-1:0]  cur_line;
  logic [OFF_W-1:0]   cur_off;
  logic [TAG_W-1:0]   cur_tag;
  logic [OFF_W-1:0]   wr_off;
  logic               accept;
  logic               out_free;
  logic               lookup_hit;
  logic               fill_write;

  logic                       ram_we;
  logic [RAM_AW-1:0]          ram_addr;
  logic [dmc_pkg::BYTE_W-1:0] ram_q;
  logic                       data_we;
  logic [DATA_AW-1:0]         data_addr;
  logic [dmc_pkg::BYTE_W-1:0] data_q;
  logic                       tag_we;
  logic [LINE_W-1:0]          tag_addr;
  logic [TAG_W-1:0]           tag_q;

  // address split
  assign in_addr_ext = {{RAM_AW{1'b0}}, in_ch.address};
  assign in_ram_addr = in_addr_ext[RAM_AW-1:0];
  assign in_line     = LINE_W'((in_ram_addr >> OFF_W) & RAM_AW'(LINE_COUNT - 1));
  assign in_off      = in_ram_addr[OFF_W-1:0];
  assign cur_line    = LINE_W'((addr_r >> OFF_W) & RAM_AW'(LINE_COUNT - 1));
  assign cur_off     = addr_r[OFF_W-1:0];
  assign cur_tag     = TAG_W'(addr_r >> (OFF_W + LCNT_W));
  assign wr_off      = OFF_W'(fill_cnt_r - 1'b1);

  assign accept     = in_ch.valid && in_ch.ready;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign lookup_hit = valid_r[cur_line] && (tag_q == cur_tag);
  assign fill_write = (state_r == dmc_pkg::ST_FILL) && (fill_cnt_r != '0);

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = (addr_r & ~RAM_AW'(LINE_BYTES - 1)) | RAM_AW'(fill_cnt_r[OFF_W-1:0]);
    data_we     = fill_write;
    data_addr   = (DATA_AW'(in_line) << OFF_W) | DATA_AW'(in_off);
    tag_we      = 1'b0;
    tag_addr    = in_line;
    unique case (state_r)
      dmc_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.kind == dmc_pkg::KIND_LOAD) begin
            ram_we    = 1'b1;
            ram_addr  = in_ram_addr;
            state_nxt = dmc_pkg::ST_RESP;
          end else begin
            state_nxt = dmc_pkg::ST_LOOKUP;
          end
        end
      end
      dmc_pkg::ST_LOOKUP: begin
        tag_addr = cur_line;
        if (lookup_hit) begin
          state_nxt = dmc_pkg::ST_RESP;
        end else begin
          tag_we    = 1'b1;
          state_nxt = dmc_pkg::ST_FILL;
        end
      end
      dmc_pkg::ST_FILL: begin
        data_addr = (DATA_AW'(cur_line) << OFF_W) | DATA_AW'(wr_off);
        if (fill_cnt_r == FCNT_W'(LINE_BYTES)) begin
          state_nxt = dmc_pkg::ST_RESP;
        end
      end
      dmc_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = dmc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dmc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      miss_cnt_r  <= '0;
      hit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == dmc_pkg::ST_LOOKUP) begin
        if (lookup_hit) begin
          if (hit_cnt_r != dmc_pkg::COUNT_MAX) begin
            hit_cnt_r <= hit_cnt_r + 1'b1;
          end
        end else begin
          valid_r[cur_line] <= 1'b1;
          if (miss_cnt_r != dmc_pkg::COUNT_MAX) begin
            miss_cnt_r <= miss_cnt_r + 1'b1;
          end
        end
      end
      if (state_r == dmc_pkg::ST_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r     <= in_ch.kind;
      addr_r     <= in_ram_addr;
      res_hit_r  <= 1'b0;
      res_byte_r <= '0;
    end
    if (state_r == dmc_pkg::ST_LOOKUP) begin
      fill_cnt_r <= '0;
      if (lookup_hit) begin
        res_hit_r  <= 1'b1;
        res_byte_r <= data_q;
      end
    end
    if (state_r == dmc_pkg::ST_FILL) begin
      fill_cnt_r <= fill_cnt_r + 1'b1;
    end
    if (fill_write && wr_off == cur_off) begin
      res_byte_r <= ram_q;
    end
    if (state_r == dmc_pkg::ST_RESP && out_free) begin
      out_hit_r  <= res_hit_r && (kind_r == dmc_pkg::KIND_ACCESS);
      out_byte_r <= res_byte_r;
      out_miss_r <= miss_cnt_r;
      out_hits_r <= hit_cnt_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.read_byte  = out_byte_r;
  assign out_ch.miss_total = out_miss_r;
  assign out_ch.hit_total  = out_hits_r;

  dmc_ram #(.WIDTH(dmc_pkg::BYTE_W), .DEPTH(RAM_BYTES)) u_backing_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_ch.load_byte),
    .rdata (ram_q)
  );

  dmc_ram #(.WIDTH(dmc_pkg::BYTE_W), .DEPTH(LINE_COUNT * LINE_BYTES)) u_line_data (
    .clk   (clk),
    .we    (data_we),
    .addr  (data_addr),
    .wdata (ram_q),
    .rdata (data_q)
  );

  dmc_ram #(.WIDTH(TAG_W), .DEPTH(LINE_COUNT)) u_line_tag (
    .clk   (clk),
    .we    (tag_we),
    .addr  (tag_addr),
    .wdata (cur_tag),
    .rdata (tag_q)
  );

`ifndef SYNTH
  a_miss_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> miss_cnt_r >= $past(miss_cnt_r))
    else $error("miss counter went backwards");

  a_hit_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> hit_cnt_r >= $past(hit_cnt_r))
    else $error("hit counter went backwards");

  a_count_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (hit_cnt_r != $past(hit_cnt_r) || miss_cnt_r != $past(miss_cnt_r)))
    |-> $past(state_r) == dmc_pkg::ST_LOOKUP)
    else $error("counter changed outside lookup");

  a_fill_then_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dmc_pkg::ST_FILL && fill_cnt_r == FCNT_W'(LINE_BYTES))
    |=> state_r == dmc_pkg::ST_RESP && $countones(valid_r) >= 1)
    else $error("fill did not complete into a valid line");
`endif

endmodule
